[design/oriented_box_corners_assert.svh]
// Assertion helpers shared by the oriented box corners RTL.
// OBC_ASSERT is disabled while reset is low, OBC_ASSERT_ALWAYS is not.
`ifndef ORIENTED_BOX_CORNERS_ASSERT_SVH
`define ORIENTED_BOX_CORNERS_ASSERT_SVH
`ifndef SYNTHESIS
`define OBC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define OBC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define OBC_ASSERT(label, prop, msg)
`define OBC_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

[design/obc_pkg.sv]
`default_nettype none

package obc_pkg;

  localparam int unsigned HEAD_W   = 17;
  localparam int unsigned SIZE_W   = 16;
  localparam int unsigned TERM_W   = 32;   // unsigned Q30 series term
  localparam int unsigned ACC_W    = 34;   // signed Q30 partial sum
  localparam int unsigned REM_W    = TERM_W + 8;
  localparam int unsigned Q_FRAC   = 30;
  localparam int unsigned PIH_W    = 31;
  localparam int unsigned SC_W     = 18;   // signed Q16 sine / cosine
  localparam int unsigned PROD_W   = SIZE_W + 1 + SC_W;
  localparam int unsigned RND_W    = 17;   // rounded rotated half extent
  localparam int unsigned NUM_CELLS = 7;
  localparam int unsigned SIN_TERMS = 6;

  localparam logic [PIH_W-1:0]  PI_HALF_Q30 = 31'd1686629713;
  localparam logic [TERM_W-1:0] Q30_ONE     = 32'd1073741824;
  localparam longint unsigned   RECIP_NUM   = 64'h1_0000_0000;

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } quad_e;

  // Data handed from cell to cell along the series chain.
  typedef struct packed {
    logic                     bad;
    quad_e                    quad;
    logic [TERM_W-1:0]        x2;
    logic [TERM_W-1:0]        term_s;
    logic [TERM_W-1:0]        term_c;
    logic signed [ACC_W-1:0]  acc_s;
    logic signed [ACC_W-1:0]  acc_c;
  } trig_t;

  // Clamp at zero, round Q30 to Q16.
  function automatic logic signed [SC_W-1:0] q30_to_q16(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = v + ACC_W'(signed'(34'sd8192));
    if (v < 0) begin
      return '0;
    end
    return t[SC_W+13:14];
  endfunction

endpackage

`default_nettype wire

[design/oriented_box_corners.sv]
`default_nettype none
`include "oriented_box_corners_assert.svh"

// Oriented box corners: give a box center, length, width and heading, get back
// the four corners (front left, back left, back right, front right) rotated
// counter-clockwise about the center, saturated to COORD_WIDTH signed bits.
// Coordinates and sizes carry 10 fractional bits; the heading counts
// 2^ANGLE_BITS units per turn, and a negative heading raises bad_heading_o
// with all corners at zero. The unit is fully pipelined: it takes one
// transaction per cycle while the output side does not stall, and each
// result passes through 2 angle stages, 7 series cells of 3 stages and
// 4 corner stages. Most of those stages belong to the chain of
// Taylor series cells that build sine and cosine, each doing one multiply,
// one reciprocal multiply and one correction step.

module oriented_box_corners #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned ANGLE_BITS  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [COORD_WIDTH-1:0]     center_x_i,
  input  logic signed [COORD_WIDTH-1:0]     center_y_i,
  input  logic [obc_pkg::SIZE_W-1:0]        box_length_i,
  input  logic [obc_pkg::SIZE_W-1:0]        box_width_i,
  input  logic signed [obc_pkg::HEAD_W-1:0] heading_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [COORD_WIDTH-1:0]     front_left_x_o,
  output logic signed [COORD_WIDTH-1:0]     front_left_y_o,
  output logic signed [COORD_WIDTH-1:0]     back_left_x_o,
  output logic signed [COORD_WIDTH-1:0]     back_left_y_o,
  output logic signed [COORD_WIDTH-1:0]     back_right_x_o,
  output logic signed [COORD_WIDTH-1:0]     back_right_y_o,
  output logic signed [COORD_WIDTH-1:0]     front_right_x_o,
  output logic signed [COORD_WIDTH-1:0]     front_right_y_o,
  output logic                              bad_heading_o
);
  import obc_pkg::*;

  // center and sizes ride alongside the series data through the angle and series stages
  localparam int unsigned SIDE_W = 2 * COORD_WIDTH + 2 * SIZE_W;

  logic [SIDE_W-1:0] side_in;
  logic              valid_c [NUM_CELLS+1];
  logic              ready_c [NUM_CELLS+1];
  trig_t             trig_c  [NUM_CELLS+1];
  logic [SIDE_W-1:0] side_c  [NUM_CELLS+1];

  logic signed [COORD_WIDTH-1:0] cx_tail, cy_tail;
  logic [SIZE_W-1:0]             len_tail, wid_tail;

  assign side_in = {center_x_i, center_y_i, box_length_i, box_width_i};

  // heading -> quadrant, Q30 angle and its square
  obc_angle #(
    .ANGLE_BITS (ANGLE_BITS),
    .SIDE_W     (SIDE_W)
  ) u_angle (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .ready_o   (in_ready_o),
    .heading_i (heading_i),
    .side_i    (side_in),
    .valid_o   (valid_c[0]),
    .ready_i   (ready_c[0]),
    .trig_o    (trig_c[0]),
    .side_o    (side_c[0])
  );

  // one cell per series term; sine stops after its sixth term
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    obc_cell #(
      .TERM_IDX (k + 1),
      .SIDE_W   (SIDE_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_c[k]),
      .ready_o (ready_c[k]),
      .trig_i  (trig_c[k]),
      .side_i  (side_c[k]),
      .valid_o (valid_c[k+1]),
      .ready_i (ready_c[k+1]),
      .trig_o  (trig_c[k+1]),
      .side_o  (side_c[k+1])
    );
  end

  assign {cx_tail, cy_tail, len_tail, wid_tail} = side_c[NUM_CELLS];

  // quadrant fold, rotation, rounding and saturation; last stage is the
  // output register
  obc_corner #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_corner (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_c[NUM_CELLS]),
    .ready_o (ready_c[NUM_CELLS]),
    .trig_i  (trig_c[NUM_CELLS]),
    .cx_i    (cx_tail),
    .cy_i    (cy_tail),
    .len_i   (len_tail),
    .wid_i   (wid_tail),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .fl_x_o  (front_left_x_o),
    .fl_y_o  (front_left_y_o),
    .bl_x_o  (back_left_x_o),
    .bl_y_o  (back_left_y_o),
    .br_x_o  (back_right_x_o),
    .br_y_o  (back_right_y_o),
    .fr_x_o  (front_right_x_o),
    .fr_y_o  (front_right_y_o),
    .bad_o   (bad_heading_o)
  );

  // An empty or draining output stage lets the whole chain move.
  `OBC_ASSERT(a_ready_when_drain, (out_ready_i || !out_valid_o) |-> in_ready_o, "input stalled while output drains")
  `OBC_ASSERT(a_bad_zero, (out_valid_o && bad_heading_o) |-> (front_left_x_o == 0 && front_left_y_o == 0 && back_left_x_o == 0 && back_left_y_o == 0 && back_right_x_o == 0 && back_right_y_o == 0 && front_right_x_o == 0 && front_right_y_o == 0), "bad heading with nonzero corner")
  `OBC_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule

`default_nettype wire

[design/obc_angle.sv]
`default_nettype none

module obc_angle #(
  parameter int unsigned ANGLE_BITS = 16,
  parameter int unsigned SIDE_W     = 96
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic signed [obc_pkg::HEAD_W-1:0] heading_i,
  input  logic [SIDE_W-1:0]                 side_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output obc_pkg::trig_t                    trig_o,
  output logic [SIDE_W-1:0]                 side_o
);
  import obc_pkg::*;

  localparam int unsigned REM_BITS = ANGLE_BITS - 2;
  localparam int unsigned MUL_W    = REM_BITS + PIH_W;
  localparam longint unsigned ROUND_HALF = 64'd1 << (REM_BITS - 1);
  localparam int unsigned SQ_W     = 2 * PIH_W;

  logic [ANGLE_BITS-1:0] turn;
  logic [MUL_W-1:0]      xmul;
  logic [SQ_W-1:0]       sq;

  logic                  rdy_a, rdy_b;
  logic                  va_q, vb_q;
  logic [PIH_W-1:0]      xa_q;
  quad_e                 quada_q;
  logic                  bada_q;
  logic [SIDE_W-1:0]     sidea_q, sideb_q;
  trig_t                 trigb_d, trigb_q;

  assign turn = ANGLE_BITS'(heading_i[HEAD_W-2:0]);
  assign xmul = MUL_W'(turn[REM_BITS-1:0]) * MUL_W'(PI_HALF_Q30) + MUL_W'(ROUND_HALF);
  assign sq   = SQ_W'(xa_q) * SQ_W'(xa_q);

  always_comb begin
    trigb_d        = '0;
    trigb_d.bad    = bada_q;
    trigb_d.quad   = quada_q;
    trigb_d.x2     = sq[Q_FRAC+TERM_W-1:Q_FRAC];
    trigb_d.term_s = TERM_W'(xa_q);
    trigb_d.term_c = Q30_ONE;
    trigb_d.acc_s  = $signed({{(ACC_W-PIH_W){1'b0}}, xa_q});
    trigb_d.acc_c  = $signed({{(ACC_W-TERM_W){1'b0}}, Q30_ONE});
  end

  assign rdy_b   = !vb_q || ready_i;
  assign rdy_a   = !va_q || rdy_b;
  assign ready_o = rdy_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (rdy_a) begin
        va_q <= valid_i;
      end
      if (rdy_b) begin
        vb_q <= va_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && valid_i) begin
      xa_q    <= xmul[MUL_W-1:REM_BITS];
      quada_q <= quad_e'(turn[ANGLE_BITS-1:ANGLE_BITS-2]);
      bada_q  <= heading_i[HEAD_W-1];
      sidea_q <= side_i;
    end
    if (rdy_b && va_q) begin
      trigb_q <= trigb_d;
      sideb_q <= sidea_q;
    end
  end

  assign valid_o = vb_q;
  assign trig_o  = trigb_q;
  assign side_o  = sideb_q;

endmodule

`default_nettype wire

[design/obc_cell.sv]
`default_nettype none

module obc_cell #(
  parameter int unsigned TERM_IDX = 1,
  parameter int unsigned SIDE_W   = 96
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  obc_pkg::trig_t    trig_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  input  logic              ready_i,
  output obc_pkg::trig_t    trig_o,
  output logic [SIDE_W-1:0] side_o
);
  import obc_pkg::*;

  localparam int unsigned DIV_S = 2 * TERM_IDX * (2 * TERM_IDX + 1);
  localparam int unsigned DIV_C = (2 * TERM_IDX - 1) * (2 * TERM_IDX);
  localparam logic [TERM_W-1:0] RECIP_S = TERM_W'(RECIP_NUM / DIV_S);
  localparam logic [TERM_W-1:0] RECIP_C = TERM_W'(RECIP_NUM / DIV_C);
  localparam bit SIN_ON   = (TERM_IDX <= SIN_TERMS);
  localparam bit SUBTRACT = ((TERM_IDX % 2) != 0);

  logic                    rdy1, rdy2, rdy3;
  logic                    v1_q, v2_q, v3_q;
  trig_t                   t1_d, t3_d;
  trig_t                   t1_q, t2_q, t3_q;
  logic [TERM_W-1:0]       es2_q, ec2_q;
  logic [SIDE_W-1:0]       side1_q, side2_q, side3_q;
  logic [2*TERM_W-1:0]     mul_s, mul_c, rcp_s, rcp_c;
  logic [REM_W-1:0]        rem_s, rem_c;
  logic [TERM_W-1:0]       fix_s, fix_c;
  logic signed [ACC_W-1:0] ext_s, ext_c;

  // stage 1: term * x^2 in Q30
  assign mul_s = (2*TERM_W)'(trig_i.term_s) * (2*TERM_W)'(trig_i.x2);
  assign mul_c = (2*TERM_W)'(trig_i.term_c) * (2*TERM_W)'(trig_i.x2);

  always_comb begin
    t1_d        = trig_i;
    t1_d.term_s = mul_s[Q_FRAC+TERM_W-1:Q_FRAC];
    t1_d.term_c = mul_c[Q_FRAC+TERM_W-1:Q_FRAC];
  end

  // stage 2: quotient estimate by reciprocal, low by at most one
  assign rcp_s = (2*TERM_W)'(t1_q.term_s) * (2*TERM_W)'(RECIP_S);
  assign rcp_c = (2*TERM_W)'(t1_q.term_c) * (2*TERM_W)'(RECIP_C);

  // stage 3: one-step correction, then accumulate
  assign rem_s = REM_W'(t2_q.term_s) - REM_W'(es2_q) * REM_W'(DIV_S);
  assign rem_c = REM_W'(t2_q.term_c) - REM_W'(ec2_q) * REM_W'(DIV_C);
  assign fix_s = es2_q + TERM_W'(rem_s >= REM_W'(DIV_S));
  assign fix_c = ec2_q + TERM_W'(rem_c >= REM_W'(DIV_C));
  assign ext_s = $signed({{(ACC_W-TERM_W){1'b0}}, fix_s});
  assign ext_c = $signed({{(ACC_W-TERM_W){1'b0}}, fix_c});

  always_comb begin
    t3_d        = t2_q;
    t3_d.term_s = fix_s;
    t3_d.term_c = fix_c;
    if (SIN_ON) begin
      t3_d.acc_s = SUBTRACT ? t2_q.acc_s - ext_s : t2_q.acc_s + ext_s;
    end
    t3_d.acc_c = SUBTRACT ? t2_q.acc_c - ext_c : t2_q.acc_c + ext_c;
  end

  assign rdy3    = !v3_q || ready_i;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      t1_q    <= t1_d;
      side1_q <= side_i;
    end
    if (rdy2 && v1_q) begin
      t2_q    <= t1_q;
      es2_q   <= rcp_s[2*TERM_W-1:TERM_W];
      ec2_q   <= rcp_c[2*TERM_W-1:TERM_W];
      side2_q <= side1_q;
    end
    if (rdy3 && v2_q) begin
      t3_q    <= t3_d;
      side3_q <= side2_q;
    end
  end

  assign valid_o = v3_q;
  assign trig_o  = t3_q;
  assign side_o  = side3_q;

endmodule

`default_nettype wire

[design/obc_corner.sv]
`default_nettype none

module obc_corner #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  obc_pkg::trig_t                    trig_i,
  input  logic signed [COORD_WIDTH-1:0]     cx_i,
  input  logic signed [COORD_WIDTH-1:0]     cy_i,
  input  logic [obc_pkg::SIZE_W-1:0]        len_i,
  input  logic [obc_pkg::SIZE_W-1:0]        wid_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output logic signed [COORD_WIDTH-1:0]     fl_x_o,
  output logic signed [COORD_WIDTH-1:0]     fl_y_o,
  output logic signed [COORD_WIDTH-1:0]     bl_x_o,
  output logic signed [COORD_WIDTH-1:0]     bl_y_o,
  output logic signed [COORD_WIDTH-1:0]     br_x_o,
  output logic signed [COORD_WIDTH-1:0]     br_y_o,
  output logic signed [COORD_WIDTH-1:0]     fr_x_o,
  output logic signed [COORD_WIDTH-1:0]     fr_y_o,
  output logic                              bad_o
);
  import obc_pkg::*;

  localparam int unsigned SUM_W = ((COORD_WIDTH > RND_W) ? COORD_WIDTH : RND_W) + 2;
  localparam logic signed [SUM_W-1:0] HI = SUM_W'({1'b0, {(COORD_WIDTH-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] LO = -HI - SUM_W'(1);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [SUM_W-1:0]       wide_t;
  typedef logic signed [RND_W-1:0]       rnd_t;
  typedef logic signed [PROD_W-1:0]      prod_t;

  function automatic rnd_t rnd(input logic signed [PROD_W:0] v);
    logic signed [PROD_W:0] t;
    t = v + (PROD_W+1)'(signed'(36'sd65536));
    return t[RND_W+16:17];
  endfunction

  function automatic coord_t sat(input wide_t v);
    wide_t t;
    t = v;
    if (v > HI) begin
      t = HI;
    end else if (v < LO) begin
      t = LO;
    end
    return t[COORD_WIDTH-1:0];
  endfunction

  logic rdy1, rdy2, rdy3, rdy4;
  logic v1_q, v2_q, v3_q, v4_q;

  // stage 1: final sine / cosine
  logic signed [SC_W-1:0] s16, c16, sn_d, cs_d;
  logic signed [SC_W-1:0] sn1_q, cs1_q;
  logic                   bad1_q, bad2_q, bad3_q, bad4_q;
  coord_t                 cx1_q, cy1_q, cx2_q, cy2_q, cx3_q, cy3_q;
  logic [SIZE_W-1:0]      len1_q, wid1_q;

  // stage 2: rotated extents
  prod_t p_lc, p_ls, p_wc, p_ws;
  prod_t plc2_q, pls2_q, pwc2_q, pws2_q;

  // stage 3: rounded for both signs of each extent
  rnd_t rlc_p_q, rlc_n_q, rls_p_q, rls_n_q, rwc_p_q, rwc_n_q, rws_p_q, rws_n_q;

  // stage 4: corner sums
  wide_t  cxw, cyw;
  coord_t fl_x_q, fl_y_q, bl_x_q, bl_y_q, br_x_q, br_y_q, fr_x_q, fr_y_q;

  assign s16 = q30_to_q16(trig_i.acc_s);
  assign c16 = q30_to_q16(trig_i.acc_c);

  always_comb begin
    unique case (trig_i.quad)
      QUAD_0: begin
        sn_d = s16;
        cs_d = c16;
      end
      QUAD_1: begin
        sn_d = c16;
        cs_d = -s16;
      end
      QUAD_2: begin
        sn_d = -s16;
        cs_d = -c16;
      end
      QUAD_3: begin
        sn_d = -c16;
        cs_d = s16;
      end
      default: begin
        sn_d = '0;
        cs_d = '0;
      end
    endcase
  end

  assign p_lc = PROD_W'($signed({1'b0, len1_q})) * PROD_W'(cs1_q);
  assign p_ls = PROD_W'($signed({1'b0, len1_q})) * PROD_W'(sn1_q);
  assign p_wc = PROD_W'($signed({1'b0, wid1_q})) * PROD_W'(cs1_q);
  assign p_ws = PROD_W'($signed({1'b0, wid1_q})) * PROD_W'(sn1_q);

  assign cxw = SUM_W'(cx3_q);
  assign cyw = SUM_W'(cy3_q);

  assign rdy4    = !v4_q || ready_i;
  assign rdy3    = !v3_q || rdy4;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      sn1_q  <= sn_d;
      cs1_q  <= cs_d;
      bad1_q <= trig_i.bad;
      cx1_q  <= cx_i;
      cy1_q  <= cy_i;
      len1_q <= len_i;
      wid1_q <= wid_i;
    end
    if (rdy2 && v1_q) begin
      plc2_q <= p_lc;
      pls2_q <= p_ls;
      pwc2_q <= p_wc;
      pws2_q <= p_ws;
      bad2_q <= bad1_q;
      cx2_q  <= cx1_q;
      cy2_q  <= cy1_q;
    end
    if (rdy3 && v2_q) begin
      // R(-p) differs from -R(p) on ties, so round each sign on its own
      rlc_p_q <= rnd((PROD_W+1)'(plc2_q));
      rlc_n_q <= rnd(-(PROD_W+1)'(plc2_q));
      rls_p_q <= rnd((PROD_W+1)'(pls2_q));
      rls_n_q <= rnd(-(PROD_W+1)'(pls2_q));
      rwc_p_q <= rnd((PROD_W+1)'(pwc2_q));
      rwc_n_q <= rnd(-(PROD_W+1)'(pwc2_q));
      rws_p_q <= rnd((PROD_W+1)'(pws2_q));
      rws_n_q <= rnd(-(PROD_W+1)'(pws2_q));
      bad3_q  <= bad2_q;
      cx3_q   <= cx2_q;
      cy3_q   <= cy2_q;
    end
    if (rdy4 && v3_q) begin
      bad4_q <= bad3_q;
      if (bad3_q) begin
        fl_x_q <= '0;
        fl_y_q <= '0;
        bl_x_q <= '0;
        bl_y_q <= '0;
        br_x_q <= '0;
        br_y_q <= '0;
        fr_x_q <= '0;
        fr_y_q <= '0;
      end else begin
        fl_x_q <= sat(cxw + SUM_W'(rlc_p_q) - SUM_W'(rws_p_q));
        fl_y_q <= sat(cyw + SUM_W'(rwc_p_q) + SUM_W'(rls_p_q));
        bl_x_q <= sat(cxw + SUM_W'(rlc_n_q) - SUM_W'(rws_p_q));
        bl_y_q <= sat(cyw + SUM_W'(rwc_p_q) + SUM_W'(rls_n_q));
        br_x_q <= sat(cxw + SUM_W'(rlc_n_q) - SUM_W'(rws_n_q));
        br_y_q <= sat(cyw + SUM_W'(rwc_n_q) + SUM_W'(rls_n_q));
        fr_x_q <= sat(cxw + SUM_W'(rlc_p_q) - SUM_W'(rws_n_q));
        fr_y_q <= sat(cyw + SUM_W'(rwc_n_q) + SUM_W'(rls_p_q));
      end
    end
  end

  assign valid_o = v4_q;
  assign bad_o   = bad4_q;
  assign fl_x_o  = fl_x_q;
  assign fl_y_o  = fl_y_q;
  assign bl_x_o  = bl_x_q;
  assign bl_y_o  = bl_y_q;
  assign br_x_o  = br_x_q;
  assign br_y_o  = br_y_q;
  assign fr_x_o  = fr_x_q;
  assign fr_y_o  = fr_y_q;

endmodule

`default_nettype wire
